/* hw/rtl/stereo_frame_ring_fifo_core_defines.svh */
// ----------------------------------------------------------------------------
// stereo frame ring fifo - assertion macros
// Concurrent assertion helpers; they reduce to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef STEREO_FRAME_RING_FIFO_CORE_DEFINES_SVH
`define STEREO_FRAME_RING_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SFRF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define SFRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFRF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SFRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/sfrf_pkg.sv */
// ----------------------------------------------------------------------------
// sfrf_pkg
// Types, sizes and helpers shared by the stereo frame ring fifo.
// ----------------------------------------------------------------------------
package sfrf_pkg;

  localparam int unsigned RING_FRAMES = 65536;
  localparam int unsigned IDX_W       = $clog2(RING_FRAMES);
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned PRIME_W     = 16;

  localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(32768);
  localparam logic [POS_W-1:0]   PRIME_FLOOR = POS_W'(48000);
  localparam logic [POS_W-1:0]   PRIME_CAP   = POS_W'(RING_FRAMES / 2);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_STATS   = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        level_t;

  // writer lead after restart: floored, then capped at half the ring
  function automatic logic [POS_W-1:0] eff_prime(logic [PRIME_W-1:0] p);
    logic [POS_W-1:0] v;
    v = POS_W'(p);
    if (v < PRIME_FLOOR) v = PRIME_FLOOR;
    if (v > PRIME_CAP) v = PRIME_CAP;
    return v;
  endfunction

  // |s| fits unsigned, the most negative value maps onto the top bit
  function automatic level_t magnitude(sample_t s);
    level_t m;
    m = s[SAMPLE_W-1] ? level_t'(-s) : level_t'(s);
    return m;
  endfunction

  function automatic level_t max_level(level_t a, level_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* hw/rtl/sfrf_if.sv */
// ----------------------------------------------------------------------------
// sfrf channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sfrf_in_if;
  logic              valid;
  logic              ready;
  sfrf_pkg::action_e action;
  sfrf_pkg::sample_t in_left;
  sfrf_pkg::sample_t in_right;

  modport source (output valid, action, in_left, in_right, input ready);
  modport sink   (input valid, action, in_left, in_right, output ready);
endinterface

interface sfrf_out_if;
  logic                                 valid;
  logic                                 ready;
  sfrf_pkg::sample_t                    out_left;
  sfrf_pkg::sample_t                    out_right;
  logic                                 was_underrun;
  logic [sfrf_pkg::CNT_W-1:0]           underrun_total;
  logic [sfrf_pkg::CNT_W-1:0]           frames_read_total;
  logic [sfrf_pkg::CNT_W-1:0]           frames_written_total;
  logic signed [sfrf_pkg::POS_W-1:0]    fill_level;
  sfrf_pkg::level_t                     peak_in_level;
  sfrf_pkg::level_t                     peak_out_level;

  modport source (output valid, out_left, out_right, was_underrun, underrun_total,
                  frames_read_total, frames_written_total, fill_level,
                  peak_in_level, peak_out_level, input ready);
  modport sink   (input valid, out_left, out_right, was_underrun, underrun_total,
                  frames_read_total, frames_written_total, fill_level,
                  peak_in_level, peak_out_level, output ready);
endinterface

/* hw/rtl/stereo_frame_ring_fifo_core.sv */
// ----------------------------------------------------------------------------
// stereo_frame_ring_fifo_core
// Ring store of stereo frames with underrun hold, counters and peak meters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request beat: write a frame, read a frame, report stats
//   (peaks cleared afterwards) or restart. Every request gives exactly one
//   result beat on out_o, in request order.
//   cfg_we_i / cfg_wdata_i set the writer lead used at the next restart;
//   write it only while no request is in flight.
// Timing:
//   an accepted request passes the single-port frame memory stage (write or
//   registered read, held in the pipeline register) and then the result
//   register. One request per cycle is taken in steady state while out_o.ready stays high.
// Reset and restart:
//   both take effect at once, with no sweep of the memory: a frame slot that
//   was not written since the last restart reads as zero, which is tracked
//   by the write offset from the restart point plus a sticky ring-full flag.
// Stall:
//   while out_o.ready is low the result register holds, one more request
//   waits in the memory stage, and then in_i.ready drops.
// ----------------------------------------------------------------------------
`include "stereo_frame_ring_fifo_core_defines.svh"

module stereo_frame_ring_fifo_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfrf_pkg::PRIME_W-1:0]  cfg_wdata_i,
  sfrf_in_if.sink                       in_i,
  sfrf_out_if.source                    out_o
);

  localparam int unsigned IDX_W    = sfrf_pkg::IDX_W;
  localparam int unsigned POS_W    = sfrf_pkg::POS_W;
  localparam int unsigned CNT_W    = sfrf_pkg::CNT_W;
  localparam int unsigned SAMPLE_W = sfrf_pkg::SAMPLE_W;

  localparam logic [POS_W-1:0] PRIME_RESET_POS =
    sfrf_pkg::eff_prime(sfrf_pkg::PRIME_RESET);

  // configuration
  logic [sfrf_pkg::PRIME_W-1:0] prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= sfrf_pkg::PRIME_RESET;
    end else if (cfg_we_i) begin
      prime_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // memory stage: positions, frame memory access, underrun decision
  // --------------------------------------------------------------------------
  logic             acc;
  logic             adv;
  logic [POS_W-1:0] wr_pos_q, wr_pos_d, rd_pos_q, rd_pos_d;
  logic [IDX_W-1:0] start_idx_q, start_idx_d;
  logic             full_q, full_d;
  logic [POS_W-1:0] diff;
  logic             under;
  logic [IDX_W-1:0] wr_idx, rd_idx, off_w, off_r;
  logic             written;
  logic             mem_we, mem_re;
  logic [POS_W-1:0] prime_pos;

  logic [2*SAMPLE_W-1:0] mem [sfrf_pkg::RING_FRAMES];
  logic [2*SAMPLE_W-1:0] mem_rdata_q;

  // pipeline register between memory stage and result stage
  logic                 p_valid_q, p_valid_d;
  sfrf_pkg::action_e    p_action_q;
  sfrf_pkg::sample_t    p_left_q, p_right_q;
  logic                 p_under_q, p_zero_q;
  logic [POS_W-1:0]     p_fill_q;

  assign acc       = in_i.valid && in_i.ready;
  assign adv       = !out_o.valid || out_o.ready;
  assign in_i.ready = !p_valid_q || adv;

  assign wr_idx    = wr_pos_q[IDX_W-1:0];
  assign rd_idx    = rd_pos_q[IDX_W-1:0];
  assign off_w     = wr_idx - start_idx_q;
  assign off_r     = rd_idx - start_idx_q;
  // slots written since restart start at the restart point
  assign written   = full_q || (off_r < off_w);
  assign diff      = wr_pos_q - rd_pos_q;
  assign under     = diff[POS_W-1] || (diff == '0);
  assign prime_pos = sfrf_pkg::eff_prime(prime_q);

  always_comb begin
    wr_pos_d    = wr_pos_q;
    rd_pos_d    = rd_pos_q;
    start_idx_d = start_idx_q;
    full_d      = full_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    if (acc) begin
      case (in_i.action)
        sfrf_pkg::ACT_WRITE: begin
          mem_we   = 1'b1;
          wr_pos_d = wr_pos_q + POS_W'(1);
          if (off_w == {IDX_W{1'b1}}) full_d = 1'b1;
        end
        sfrf_pkg::ACT_READ: begin
          mem_re   = 1'b1;
          rd_pos_d = rd_pos_q + POS_W'(1);
        end
        sfrf_pkg::ACT_RESTART: begin
          wr_pos_d    = prime_pos;
          rd_pos_d    = '0;
          start_idx_d = prime_pos[IDX_W-1:0];
          full_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q    <= PRIME_RESET_POS;
      rd_pos_q    <= '0;
      start_idx_q <= PRIME_RESET_POS[IDX_W-1:0];
      full_q      <= 1'b0;
    end else begin
      wr_pos_q    <= wr_pos_d;
      rd_pos_q    <= rd_pos_d;
      start_idx_q <= start_idx_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= {in_i.in_right, in_i.in_left};
    end
    if (mem_re) begin
      mem_rdata_q <= mem[rd_idx];
    end
  end

  always_comb begin
    p_valid_d = p_valid_q;
    if (acc) begin
      p_valid_d = 1'b1;
    end else if (adv) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_action_q <= in_i.action;
      p_left_q   <= in_i.in_left;
      p_right_q  <= in_i.in_right;
      p_under_q  <= (in_i.action == sfrf_pkg::ACT_READ) && under;
      p_zero_q   <= !written;
      p_fill_q   <= wr_pos_d - rd_pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // result stage: held frame, counters, peaks, result register
  // --------------------------------------------------------------------------
  sfrf_pkg::sample_t held_l_q, held_l_d, held_r_q, held_r_d;
  logic [CNT_W-1:0]  ur_cnt_q, ur_cnt_d, rd_cnt_q, rd_cnt_d, wr_cnt_q, wr_cnt_d;
  sfrf_pkg::level_t  pk_in_q, pk_in_d, pk_out_q, pk_out_d;
  sfrf_pkg::level_t  rep_in, rep_out;
  sfrf_pkg::sample_t o_left, o_right;
  sfrf_pkg::sample_t rd_left, rd_right;
  logic              step;

  logic                 out_valid_q;
  sfrf_pkg::sample_t    o_left_q, o_right_q;
  logic                 o_under_q;
  logic [CNT_W-1:0]     o_ur_q, o_rd_q, o_wr_q;
  logic [POS_W-1:0]     o_fill_q;
  sfrf_pkg::level_t     o_pk_in_q, o_pk_out_q;

  assign step = p_valid_q && adv;

  // never-written slot reads as zero
  assign rd_left  = p_zero_q ? '0 : sfrf_pkg::sample_t'(mem_rdata_q[SAMPLE_W-1:0]);
  assign rd_right = p_zero_q ? '0 : sfrf_pkg::sample_t'(mem_rdata_q[2*SAMPLE_W-1:SAMPLE_W]);

  always_comb begin
    held_l_d = held_l_q;
    held_r_d = held_r_q;
    ur_cnt_d = ur_cnt_q;
    rd_cnt_d = rd_cnt_q;
    wr_cnt_d = wr_cnt_q;
    pk_in_d  = pk_in_q;
    pk_out_d = pk_out_q;
    o_left   = '0;
    o_right  = '0;
    case (p_action_q)
      sfrf_pkg::ACT_WRITE: begin
        pk_in_d  = sfrf_pkg::max_level(pk_in_q,
                     sfrf_pkg::max_level(sfrf_pkg::magnitude(p_left_q),
                                         sfrf_pkg::magnitude(p_right_q)));
        wr_cnt_d = wr_cnt_q + CNT_W'(1);
      end
      sfrf_pkg::ACT_READ: begin
        if (p_under_q) begin
          ur_cnt_d = ur_cnt_q + CNT_W'(1);
        end else begin
          held_l_d = rd_left;
          held_r_d = rd_right;
        end
        o_left   = held_l_d;
        o_right  = held_r_d;
        pk_out_d = sfrf_pkg::max_level(pk_out_q,
                     sfrf_pkg::max_level(sfrf_pkg::magnitude(held_l_d),
                                         sfrf_pkg::magnitude(held_r_d)));
        rd_cnt_d = rd_cnt_q + CNT_W'(1);
      end
      sfrf_pkg::ACT_RESTART: begin
        held_l_d = '0;
        held_r_d = '0;
        ur_cnt_d = '0;
        rd_cnt_d = '0;
        wr_cnt_d = '0;
        pk_in_d  = '0;
        pk_out_d = '0;
      end
      default: begin
      end
    endcase
    rep_in  = pk_in_d;
    rep_out = pk_out_d;
    // stats reports the peaks, then clears them
    if (p_action_q == sfrf_pkg::ACT_STATS) begin
      pk_in_d  = '0;
      pk_out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_l_q    <= '0;
      held_r_q    <= '0;
      ur_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      pk_in_q     <= '0;
      pk_out_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        held_l_q <= held_l_d;
        held_r_q <= held_r_d;
        ur_cnt_q <= ur_cnt_d;
        rd_cnt_q <= rd_cnt_d;
        wr_cnt_q <= wr_cnt_d;
        pk_in_q  <= pk_in_d;
        pk_out_q <= pk_out_d;
      end
      if (adv) begin
        out_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      o_left_q   <= o_left;
      o_right_q  <= o_right;
      o_under_q  <= p_under_q;
      o_ur_q     <= ur_cnt_d;
      o_rd_q     <= rd_cnt_d;
      o_wr_q     <= wr_cnt_d;
      o_fill_q   <= p_fill_q;
      o_pk_in_q  <= rep_in;
      o_pk_out_q <= rep_out;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.out_left             = o_left_q;
  assign out_o.out_right            = o_right_q;
  assign out_o.was_underrun         = o_under_q;
  assign out_o.underrun_total       = o_ur_q;
  assign out_o.frames_read_total    = o_rd_q;
  assign out_o.frames_written_total = o_wr_q;
  assign out_o.fill_level           = $signed(o_fill_q);
  assign out_o.peak_in_level        = o_pk_in_q;
  assign out_o.peak_out_level       = o_pk_out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SFRF_ASSERT_IMPL(a_under_only_read, clk_i, rst_ni,
    p_valid_q && p_under_q, p_action_q == sfrf_pkg::ACT_READ,
    "underrun flagged on a beat that is not a read")
  `SFRF_ASSERT_NEXT(a_restart_clears_rd, clk_i, rst_ni,
    acc && (in_i.action == sfrf_pkg::ACT_RESTART), (rd_pos_q == '0) && !full_q,
    "restart did not reset the read side")
  `SFRF_ASSERT_NEXT(a_pipe_holds, clk_i, rst_ni,
    p_valid_q && !adv, p_valid_q,
    "memory stage beat dropped during output stall")
  `SFRF_ASSERT_IMPL(a_full_sticky, clk_i, rst_ni,
    $fell(full_q), $past(acc) && ($past(in_i.action) == sfrf_pkg::ACT_RESTART),
    "ring full flag cleared without restart")

endmodule
